/* hw/rtl/grbf_pkg.sv */
// Shared types, constants and the reciprocal table for the Gaussian RBF expander.
// Used by every module under hw/rtl; depends on nothing.
package grbf_pkg;

  localparam int MAX_CENTERS  = 16;
  localparam int K_W          = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CNT_W        = $clog2(MAX_CENTERS + 1);
  localparam int SERIES_TERMS = 10;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  typedef enum logic [1:0] {
    REG_GRID_START  = 2'd0,
    REG_INV_SPACING = 2'd1,
    REG_GRID_SIZE   = 2'd2
  } reg_idx_t;

  // one center of one sample, leaving the sequencer
  typedef struct packed {
    logic             valid;
    logic [K_W-1:0]   k;
    logic             last;
    logic [16:0]      diff;   // grid_start - sample, signed Q4.12
  } cent_t;

  // sideband that rides along the exponent pipeline
  typedef struct packed {
    logic             valid;
    logic [K_W-1:0]   k;
    logic             last;
    logic             far;    // |d| >= 4.0, result forced to zero
    logic             pos;    // d > 0, slope negative
    logic [13:0]      a12;    // |d| in Q.12
    logic [4:0]       n;      // integer part of d*d*log2(e)
  } band_t;

  // state of the exp series between term units
  typedef struct packed {
    band_t            band;
    logic [29:0]      g30;    // frac * ln2, Q.30
    logic [30:0]      term;   // current series term, Q.30
    logic [31:0]      sum;    // running alternating sum, Q.30
  } ser_t;

  // floor(2^32 / i): reciprocal for dividing a term by its index
  function automatic logic [32:0] recip(input logic [3:0] i);
    logic [32:0] m;
    case (i)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/grbf_front.sv */
// Configuration registers and the center sequencer: one sample in, one center word a cycle out
// while adv is high. Depends on grbf_pkg.
module grbf_front import grbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // [15:0] sample
  input  logic        adv,
  output cent_t       item,
  output logic [15:0] inv_spacing
);

  logic [15:0]      grid_start;
  logic [4:0]       grid_size;
  logic             cur_valid;
  logic [K_W-1:0]   cur_k;
  logic [CNT_W-1:0] cur_count;
  logic [16:0]      cur_diff;
  logic [CNT_W-1:0] count_next;
  logic [16:0]      diff_next;

  always_comb begin
    if (grid_size == 5'd0) begin
      count_next = CNT_W'(1);
    end else if (int'(grid_size) > MAX_CENTERS) begin
      count_next = CNT_W'(MAX_CENTERS);
    end else begin
      count_next = CNT_W'(grid_size);
    end
  end

  assign diff_next = 17'($signed({grid_start[15], grid_start}) - $signed({s_tdata[15], s_tdata}));

  always_comb begin
    item.valid = cur_valid;
    item.k     = cur_k;
    item.last  = (CNT_W'(cur_k) + CNT_W'(1)) == cur_count;
    item.diff  = cur_diff;
  end

  // take a new sample when idle or while the final center of the current one issues
  assign s_tready = adv && (!cur_valid || item.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      grid_start  <= 16'd0;
      inv_spacing <= 16'd0;
      grid_size   <= 5'd1;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_GRID_START:  grid_start  <= cfg_wdata;
          REG_INV_SPACING: inv_spacing <= cfg_wdata;
          REG_GRID_SIZE:   grid_size   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        cur_valid <= 1'b1;
        cur_k     <= '0;
        cur_count <= count_next;
        cur_diff  <= diff_next;
      end else if (adv && cur_valid) begin
        if (item.last) begin
          cur_valid <= 1'b0;
        end else begin
          cur_k <= cur_k + K_W'(1);
        end
      end
    end
  end

endmodule

/* hw/rtl/grbf_dist.sv */
// Distance stages: scaled offset, |d| rounding, d*d*log2(e) split into integer and fraction,
// and the fraction times ln2 that seeds the exp series. Six register stages. Depends on grbf_pkg.
module grbf_dist import grbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cent_t       item,
  input  logic [15:0] inv_spacing,
  output ser_t        out
);

  band_t       b1, b2, b3, b4, b5;
  band_t       nb3, nb5;
  logic [33:0] prod1;
  logic [34:0] d20_2;
  logic [27:0] sq4;
  logic [23:0] f5;
  logic [34:0] a20;
  logic [34:0] a12_full;
  logic [44:0] u_prod;
  logic [53:0] g_prod;
  band_t       nb1;

  always_comb begin
    nb1       = '0;
    nb1.valid = item.valid;
    nb1.k     = item.k;
    nb1.last  = item.last;
  end

  // stage 3 logic: magnitude, round half away from zero, far check
  always_comb begin
    a20       = d20_2[34] ? (35'd0 - d20_2) : d20_2;
    a12_full  = (a20 + 35'd128) >> 8;
    nb3       = b2;
    nb3.pos   = !d20_2[34] && (d20_2 != 35'd0);
    nb3.far   = |a12_full[34:14];
    nb3.a12   = a12_full[13:0];
  end

  always_comb begin
    u_prod = 45'(sq4) * 45'(LOG2E_Q16) + 45'd32768;
    nb5    = b4;
    nb5.n  = u_prod[44:40];
  end

  assign g_prod = 54'(f5) * 54'(LN2_Q30) + 54'd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.valid      <= 1'b0;
      b2.valid      <= 1'b0;
      b3.valid      <= 1'b0;
      b4.valid      <= 1'b0;
      b5.valid      <= 1'b0;
      out.band.valid <= 1'b0;
    end else if (adv) begin
      b1    <= nb1;
      prod1 <= 34'($signed(item.diff) * $signed({1'b0, inv_spacing}));
      b2    <= b1;
      d20_2 <= 35'($signed({prod1[33], prod1}) + $signed(35'(b1.k) << 20));
      b3    <= nb3;
      b4    <= b3;
      sq4   <= 28'(b3.a12) * 28'(b3.a12);
      b5    <= nb5;
      f5    <= u_prod[39:16];
      out.band <= b5;
      out.g30  <= g_prod[53:24];
      out.term <= 31'h4000_0000;
      out.sum  <= 32'h4000_0000;
    end
  end

endmodule

/* hw/rtl/grbf_term.sv */
// One term of the exp(-g) series: multiply by g, divide by the term index through a
// reciprocal with one correction, then fold into the alternating sum. Three stages. Uses grbf_pkg.
module grbf_term import grbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic [3:0] term_idx,
  input  ser_t       in,
  output ser_t       out
);

  ser_t        sa, sb;
  logic [30:0] raw_a, raw_b, q0_b;
  logic [60:0] mul;
  logic [63:0] mq;
  logic [34:0] rem;
  logic [30:0] q;

  assign mul = 61'(in.term) * 61'(in.g30);
  assign mq  = 64'(raw_a) * 64'(recip(term_idx));

  // reciprocal estimate is at most one low
  always_comb begin
    rem = 35'(raw_b) - 35'(q0_b) * 35'(term_idx);
    q   = (rem >= 35'(term_idx)) ? q0_b + 31'd1 : q0_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.band.valid  <= 1'b0;
      sb.band.valid  <= 1'b0;
      out.band.valid <= 1'b0;
    end else if (adv) begin
      sa    <= in;
      raw_a <= mul[60:30];
      sb    <= sa;
      raw_b <= raw_a;
      q0_b  <= mq[62:32];
      out.band <= sb.band;
      out.g30  <= sb.g30;
      out.term <= q;
      out.sum  <= term_idx[0] ? sb.sum - 32'(q) : sb.sum + 32'(q);
    end
  end

endmodule

/* hw/rtl/grbf_out.sv */
// Output stages: scale the series result by 2^-n into basis and slope, apply sign and the
// far-from-center zeroing, and hold the output register. Three stages. Depends on grbf_pkg.
module grbf_out import grbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  ser_t        in,
  output logic        m_tvalid,
  output logic [39:0] m_tdata,   // [15:0] basis, [31:16] slope, [35:32] center_index, zero above
  output logic        m_tlast
);

  band_t       b1, b2;
  logic [30:0] e30;
  logic [5:0]  sh_b, sh_s;
  logic [38:0] bsum, bfull;
  logic [44:0] mprod1;
  logic [15:0] basis1, basis2, mag2;
  logic [48:0] ssum, sfull;
  logic [15:0] slope_v, basis_v;

  always_comb begin
    e30   = in.sum[30:0];
    sh_b  = 6'(in.band.n) + 6'd14;
    bsum  = 39'(e30) + (39'd1 << sh_b);
    bfull = bsum >> (sh_b + 6'd1);
  end

  always_comb begin
    sh_s  = 6'(b1.n) + 6'd25;
    ssum  = 49'(mprod1) + (49'd1 << sh_s);
    sfull = ssum >> (sh_s + 6'd1);
  end

  always_comb begin
    if (b2.far) begin
      basis_v = 16'd0;
      slope_v = 16'd0;
    end else begin
      basis_v = basis2;
      slope_v = b2.pos ? 16'd0 - mag2 : mag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.valid <= 1'b0;
      b2.valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      b1       <= in.band;
      mprod1   <= 45'(in.band.a12) * 45'(e30);
      basis1   <= bfull[15:0];
      b2       <= b1;
      mag2     <= sfull[15:0];
      basis2   <= basis1;
      m_tvalid <= b2.valid;
      m_tdata  <= {4'd0, 4'(b2.k), slope_v, basis_v};
      m_tlast  <= b2.last;
    end
  end

endmodule

/* hw/rtl/gaussian_rbf_basis_expander.sv */
// Gaussian RBF basis expander: each sample yields one word per grid center (exp(-d^2), -2d*exp(-d^2)).
// A sample's words pass through the distance stages, the series term units and the output stages.
// Throughput: one word per cycle unless stalled; samples are taken as the prior's last center issues.
// The whole pipeline advances together and freezes while the output word waits.
// Synchronous reset clears all valid bits and sets grid_start 0, inv_spacing 0, grid_size 1.
module gaussian_rbf_basis_expander import grbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] basis, [31:16] slope, [35:32] center_index, zero above
  output logic        m_tlast
);

  logic        adv;
  cent_t       item;
  logic [15:0] inv_spacing;
  ser_t        chain [SERIES_TERMS+1];

  // advance every stage unless the output word is held
  assign adv = !m_tvalid || m_tready;

  grbf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .adv         (adv),
    .item        (item),
    .inv_spacing (inv_spacing)
  );

  grbf_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .item        (item),
    .inv_spacing (inv_spacing),
    .out         (chain[0])
  );

  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_term
    grbf_term u_term (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .term_idx (4'(g + 1)),
      .in       (chain[g]),
      .out      (chain[g+1])
    );
  end

  grbf_out u_out (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in       (chain[SERIES_TERMS]),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("sample taken while output word stalled");

  a_basis_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= 16'd32768))
    else $error("basis above one");

  a_next_sample_from_zero: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.last && adv) |=> (!item.valid || item.k == '0))
    else $error("new sample does not start at center zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid after reset");
`endif

endmodule
